>>> hdl/cd_pkg.sv
package cd_pkg;

  // Fixed-point format of the result: unsigned Q2.16, range 0..2.0
  localparam int FRAC_W     = 16;
  localparam int Q_W        = FRAC_W + 2;
  localparam int OUT_W      = 18;
  localparam int OUT_DATA_W = 24;

  localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(1 << FRAC_W);

  localparam int DEF_MAX_LEN   = 1024;
  localparam int DEF_ELEM_BITS = 16;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_ZCHK,
    ST_MUL,
    ST_SQRT,
    ST_DCHK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] value;
    logic             zflag;
  } res_t;

endpackage

>>> hdl/cd_mac.sv
module cd_mac #(
  parameter int ELEM_BITS = 16,
  parameter int MAG_W     = 41,
  parameter int DOT_W     = 43
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_accept,
  input  logic signed [ELEM_BITS-1:0] x_elem,
  input  logic signed [ELEM_BITS-1:0] y_elem,
  input  logic                    acc_clr,
  output logic signed [DOT_W-1:0] dot_sum,
  output logic [MAG_W-1:0]        x_mag_sum,
  output logic [MAG_W-1:0]        y_mag_sum
);
  import cd_pkg::*;

  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int SQ_W   = PROD_W - 1;

  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [MAG_W-1:0]        MAG_MAX = {MAG_W{1'b1}};

  logic                     p_valid_r;
  logic signed [PROD_W-1:0] pxy_r;
  logic [SQ_W-1:0]          pxx_r;
  logic [SQ_W-1:0]          pyy_r;

  logic signed [PROD_W-1:0] pxy;
  logic signed [PROD_W-1:0] pxx;
  logic signed [PROD_W-1:0] pyy;

  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic [MAG_W-1:0]         xm_r, xm_nxt;
  logic [MAG_W-1:0]         ym_r, ym_nxt;

  logic signed [DOT_W:0]    dsum;
  logic [MAG_W:0]           xsum;
  logic [MAG_W:0]           ysum;

  assign pxy = x_elem * y_elem;
  assign pxx = x_elem * x_elem;
  assign pyy = y_elem * y_elem;

  // Product stage: register the three products of the accepted pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pxy_r <= pxy;
      pxx_r <= pxx[SQ_W-1:0];
      pyy_r <= pyy[SQ_W-1:0];
    end
  end

  // Accumulate stage with saturation at the accumulator bounds
  always_comb begin
    dsum = (DOT_W+1)'(dot_r) + (DOT_W+1)'(pxy_r);
    xsum = {1'b0, xm_r} + (MAG_W+1)'(pxx_r);
    ysum = {1'b0, ym_r} + (MAG_W+1)'(pyy_r);

    dot_nxt = dot_r;
    xm_nxt  = xm_r;
    ym_nxt  = ym_r;
    if (acc_clr) begin
      dot_nxt = '0;
      xm_nxt  = '0;
      ym_nxt  = '0;
    end else if (p_valid_r) begin
      if (dsum[DOT_W] != dsum[DOT_W-1]) begin
        dot_nxt = dsum[DOT_W] ? DOT_MIN : DOT_MAX;
      end else begin
        dot_nxt = dsum[DOT_W-1:0];
      end
      xm_nxt = xsum[MAG_W] ? MAG_MAX : xsum[MAG_W-1:0];
      ym_nxt = ysum[MAG_W] ? MAG_MAX : ysum[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      xm_r  <= '0;
      ym_r  <= '0;
    end else begin
      dot_r <= dot_nxt;
      xm_r  <= xm_nxt;
      ym_r  <= ym_nxt;
    end
  end

  assign dot_sum   = dot_r;
  assign x_mag_sum = xm_r;
  assign y_mag_sum = ym_r;

endmodule

>>> hdl/cd_alu.sv
module cd_alu #(
  parameter int ALU_W = 44
) (
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W:0]   y
);
  import cd_pkg::*;

  // y = a + b or a - b; for subtract, y[ALU_W] set means a < b
  assign y = {1'b0, a} + ({1'b0, b} ^ {(ALU_W+1){sub}}) + (ALU_W+1)'(sub);

endmodule

>>> hdl/cd_seq.sv
module cd_seq #(
  parameter int MAG_W = 41,
  parameter int DOT_W = 43
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_accept,
  input  logic                    in_last,
  output logic                    in_ready,
  input  logic signed [DOT_W-1:0] dot_sum,
  input  logic [MAG_W-1:0]        x_mag_sum,
  input  logic [MAG_W-1:0]        y_mag_sum,
  output logic                    acc_clr,
  input  logic                    out_free,
  output cd_pkg::res_t            res
);
  import cd_pkg::*;

  localparam int ALU_W   = MAG_W + 3;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int CNT_MAX = (MAG_W > Q_W) ? MAG_W : Q_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [ALU_W-1:0]   rem_r, rem_nxt;
  logic [MAG_W-1:0]   root_r, root_nxt;
  logic [DOT_W-1:0]   dabs_r, dabs_nxt;
  logic               dneg_r, dneg_nxt;
  logic [Q_W-1:0]     nbits_r, nbits_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic               zflag_r, zflag_nxt;

  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_sub;
  logic [ALU_W:0]     alu_y;
  logic [ALU_W-1:0]   remsh;
  logic               mag_zero;
  logic               last_step;
  logic [Q_W-1:0]     qc;

  cd_alu #(.ALU_W(ALU_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign mag_zero  = (x_mag_sum == '0) || (y_mag_sum == '0);
  assign last_step = (cnt_r == CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC: begin
        if (in_accept && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_ZCHK;
      ST_ZCHK: begin
        state_nxt = mag_zero ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        if (last_step) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (last_step) state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        state_nxt = alu_y[ALU_W] ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (last_step) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dabs_nxt  = dabs_r;
    dneg_nxt  = dneg_r;
    nbits_nxt = nbits_r;
    q_nxt     = q_r;
    zflag_nxt = zflag_r;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    remsh     = '0;
    in_ready  = 1'b0;
    acc_clr   = 1'b0;
    res.valid = 1'b0;

    qc        = (q_r > Q_W'(ONE_Q16)) ? Q_W'(ONE_Q16) : q_r;
    res.value = dneg_r ? (ONE_Q16 + OUT_W'(qc)) : (ONE_Q16 - OUT_W'(qc));
    res.zflag = zflag_r;

    unique case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_ZCHK: begin
        // Negate the dot sum through the adder; keep its magnitude and sign
        alu_b    = ALU_W'(dot_sum);
        alu_sub  = 1'b1;
        dneg_nxt = dot_sum[DOT_W-1];
        dabs_nxt = dot_sum[DOT_W-1] ? alu_y[DOT_W-1:0] : dot_sum;
        if (mag_zero) begin
          zflag_nxt = 1'b1;
          q_nxt     = '0;
        end else begin
          zflag_nxt = 1'b0;
          prod_nxt  = {{MAG_W{1'b0}}, y_mag_sum};
          cnt_nxt   = CNT_W'(MAG_W);
        end
      end
      ST_MUL: begin
        // Shift-add: add the multiplicand into the upper half, shift right
        alu_a    = ALU_W'(prod_r[PROD_W-1:MAG_W]);
        alu_b    = prod_r[0] ? ALU_W'(x_mag_sum) : '0;
        prod_nxt = {alu_y[MAG_W:0], prod_r[MAG_W-1:1]};
        if (last_step) begin
          cnt_nxt  = CNT_W'(MAG_W);
          rem_nxt  = '0;
          root_nxt = '0;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_SQRT: begin
        // One root bit a step: bring down two operand bits, try root*4+1
        remsh    = {rem_r[ALU_W-3:0], prod_r[PROD_W-1 -: 2]};
        alu_a    = remsh;
        alu_b    = ALU_W'({root_r, 2'b01});
        alu_sub  = 1'b1;
        prod_nxt = {prod_r[PROD_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (!alu_y[ALU_W]) begin
          rem_nxt  = alu_y[ALU_W-1:0];
          root_nxt = {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = remsh;
          root_nxt = {root_r[MAG_W-2:0], 1'b0};
        end
      end
      ST_DCHK: begin
        // Quotient would need more than Q_W bits: clamp at one
        alu_a   = ALU_W'(dabs_r[DOT_W-1:2]);
        alu_b   = ALU_W'(root_r);
        alu_sub = 1'b1;
        if (!alu_y[ALU_W]) begin
          q_nxt = Q_W'(ONE_Q16);
        end else begin
          rem_nxt   = ALU_W'(dabs_r[DOT_W-1:2]);
          nbits_nxt = {dabs_r[1:0], {FRAC_W{1'b0}}};
          q_nxt     = '0;
          cnt_nxt   = CNT_W'(Q_W);
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a step
        remsh     = {rem_r[ALU_W-2:0], nbits_r[Q_W-1]};
        alu_a     = remsh;
        alu_b     = ALU_W'(root_r);
        alu_sub   = 1'b1;
        nbits_nxt = {nbits_r[Q_W-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        q_nxt     = {q_r[Q_W-2:0], ~alu_y[ALU_W]};
        rem_nxt   = alu_y[ALU_W] ? remsh : alu_y[ALU_W-1:0];
      end
      ST_DONE: begin
        res.valid = out_free;
        acc_clr   = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    dabs_r  <= dabs_nxt;
    dneg_r  <= dneg_nxt;
    nbits_r <= nbits_nxt;
    q_r     <= q_nxt;
    zflag_r <= zflag_nxt;
  end

  a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result issued while output register is full");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !zflag_r |-> (root_r != '0))
    else $error("zero root on a nonzero-magnitude result");

  a_mags_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !zflag_r |-> (x_mag_sum != '0) && (y_mag_sum != '0))
    else $error("magnitude sums lost before result");

endmodule

>>> hdl/cosine_dissimilarity_core.sv
// Cosine dissimilarity of two streamed signed vectors. Each input transaction
// carries one element pair (x in tdata low half, y above it) and tlast marks
// the final pair. While a vector streams in, the core takes one pair every
// cycle; the dot product and both squared magnitudes accumulate with
// saturation at their register bounds. After the pair with tlast, in_tready
// drops while a single shared add/subtract unit works through the result:
// a drain state, a check state, MAG_W shift-add steps for the magnitude
// product (MAG_W = 41 at the defaults), MAG_W steps of the digit-by-digit
// square root, an overflow check and 18 restoring-division steps, then a
// state that loads the output register. The division steps are skipped when
// the overflow check already clamps the quotient, and all steps after the
// check state are skipped when either magnitude is zero. The last state holds
// for as long as an earlier result still waits in the output register. The
// result transaction gives 65536 - q in unsigned Q2.16 (0..131072), where q =
// dot*65536/floor(sqrt(|x|^2*|y|^2)) truncated toward zero and clamped to
// +-65536; with a zero magnitude it gives 65536 and raises tuser. The result
// sits in an output register, so a new vector may stream in while it waits
// to be taken. Vectors longer than MAX_LEN may saturate the accumulators.
module cosine_dissimilarity_core #(
  parameter int MAX_LEN   = cd_pkg::DEF_MAX_LEN,
  parameter int ELEM_BITS = cd_pkg::DEF_ELEM_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((2*ELEM_BITS+7)/8)*8-1:0]      in_tdata,   // x_elem, y_elem
  input  logic                                  in_tlast,   // last
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cd_pkg::OUT_DATA_W-1:0]         out_tdata,  // dissimilarity
  output logic                                  out_tuser   // zero_magnitude
);
  import cd_pkg::*;

  localparam int MAG_W = 2 * ELEM_BITS + $clog2(MAX_LEN) - 1;
  localparam int DOT_W = MAG_W + 2;

  logic                        in_accept;
  logic signed [ELEM_BITS-1:0] x_elem;
  logic signed [ELEM_BITS-1:0] y_elem;
  logic signed [DOT_W-1:0]     dot_sum;
  logic [MAG_W-1:0]            x_mag_sum;
  logic [MAG_W-1:0]            y_mag_sum;
  logic                        acc_clr;
  logic                        out_free;
  res_t                        res;

  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_value_r;
  logic                        out_zflag_r;

  assign in_accept = in_tvalid && in_tready;
  assign x_elem    = in_tdata[ELEM_BITS-1:0];
  assign y_elem    = in_tdata[2*ELEM_BITS-1:ELEM_BITS];

  cd_mac #(
    .ELEM_BITS (ELEM_BITS),
    .MAG_W     (MAG_W),
    .DOT_W     (DOT_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .x_elem    (x_elem),
    .y_elem    (y_elem),
    .acc_clr   (acc_clr),
    .dot_sum   (dot_sum),
    .x_mag_sum (x_mag_sum),
    .y_mag_sum (y_mag_sum)
  );

  cd_seq #(
    .MAG_W (MAG_W),
    .DOT_W (DOT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .dot_sum   (dot_sum),
    .x_mag_sum (x_mag_sum),
    .y_mag_sum (y_mag_sum),
    .acc_clr   (acc_clr),
    .out_free  (out_free),
    .res       (res)
  );

  // Output register: free when empty or when its transaction completes now
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r <= res.value;
      out_zflag_r <= res.zflag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_value_r);
  assign out_tuser  = out_zflag_r;

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r <= (ONE_Q16 + ONE_Q16)))
    else $error("dissimilarity above 2.0");

  a_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zflag_r |-> (out_value_r == ONE_Q16))
    else $error("zero-magnitude result is not one");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> !in_tready)
    else $error("input accepted while computing result");

endmodule
